@@ hdl/ipws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipws_pkg
// Shared widths, saturating helpers, datapath operation codes and the
// command, status and configuration bundles of the wheel speed PID unit.
// ----------------------------------------------------------------------------
package ipws_pkg;

  // Fixed field widths
  localparam int unsigned ENC_W     = 32;
  localparam int unsigned TARGET_W  = 16;
  localparam int unsigned DRIVE_W   = 16;
  localparam int unsigned OUT_MAX_W = 15;
  localparam int unsigned GAIN_W    = 10;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned PADDR_W   = 5;

  // Intermediate arithmetic: signed 64-bit with saturation
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned WIDE_X = WIDE_W + 1;
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

  // Shared multiplier: one 64-bit operand taken in two 32-bit halves
  localparam int unsigned HALF_W  = WIDE_W / 2;
  localparam int unsigned MUL_A_W = HALF_W + 1;
  localparam int unsigned MUL_G_W = GAIN_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_G_W;
  localparam int unsigned FULL_W  = MUL_P_W + HALF_W;

  // Serial divider: quotient bits per cycle
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_CYCLES = WIDE_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RESET,
    OP_DELTA,
    OP_NEGD,
    OP_ERR,
    OP_NEGL,
    OP_DDIF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_FIN,
    OP_SETP,
    OP_NEGP,
    OP_SUBD,
    OP_ADDI,
    OP_DIV_GO,
    OP_DRIVE,
    OP_CLAMP,
    OP_INTEG,
    OP_OUT
  } dp_op_e;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MS_P,
    MS_D,
    MS_I
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e msel;
  } ipws_cmd_t;

  typedef struct packed {
    logic is_reset;
    logic div_done;
    logic clamp_hit;
  } ipws_status_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]   out_min;
    logic [OUT_MAX_W-1:0] out_max;
    logic [GAIN_W-1:0]    gain_p;
    logic [GAIN_W-1:0]    gain_i;
    logic [GAIN_W-1:0]    gain_d;
    logic [GAIN_W-1:0]    gain_div;
  } ipws_cfg_t;

  // Saturating signed add
  function automatic logic signed [WIDE_W-1:0] sat_add(
    input logic signed [WIDE_W-1:0] a,
    input logic signed [WIDE_W-1:0] b
  );
    logic signed [WIDE_W:0] s;
    s = WIDE_X'(a) + WIDE_X'(b);
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      return s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end
    return s[WIDE_W-1:0];
  endfunction

  // Saturating negate
  function automatic logic signed [WIDE_W-1:0] sat_neg(
    input logic signed [WIDE_W-1:0] a
  );
    return (a == WIDE_MIN) ? WIDE_MAX : -a;
  endfunction

endpackage

@@ hdl/ipws_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipws_cfg
// APB-style register file holding the drive limits and the PID gains.
// ----------------------------------------------------------------------------
module ipws_cfg import ipws_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  output ipws_cfg_t          cfg
);

  typedef enum logic [2:0] {
    REG_OUT_MIN  = 3'd0,
    REG_OUT_MAX  = 3'd1,
    REG_GAIN_P   = 3'd2,
    REG_GAIN_I   = 3'd3,
    REG_GAIN_D   = 3'd4,
    REG_GAIN_DIV = 3'd5
  } reg_idx_e;

  ipws_cfg_t cfg_r;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_min  <= DRIVE_W'(-255);
      cfg_r.out_max  <= OUT_MAX_W'(255);
      cfg_r.gain_p   <= GAIN_W'(4);
      cfg_r.gain_i   <= GAIN_W'(0);
      cfg_r.gain_d   <= GAIN_W'(1);
      cfg_r.gain_div <= GAIN_W'(50);
    end else if (wr_en) begin
      unique case (idx)
        REG_OUT_MIN:  cfg_r.out_min  <= pwdata[DRIVE_W-1:0];
        REG_OUT_MAX:  cfg_r.out_max  <= pwdata[OUT_MAX_W-1:0];
        REG_GAIN_P:   cfg_r.gain_p   <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:   cfg_r.gain_i   <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:   cfg_r.gain_d   <= pwdata[GAIN_W-1:0];
        REG_GAIN_DIV: cfg_r.gain_div <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, lower limit sign-extended
  always_comb begin
    unique case (idx)
      REG_OUT_MIN:  prdata = CFG_DW'(signed'(cfg_r.out_min));
      REG_OUT_MAX:  prdata = CFG_DW'(cfg_r.out_max);
      REG_GAIN_P:   prdata = CFG_DW'(cfg_r.gain_p);
      REG_GAIN_I:   prdata = CFG_DW'(cfg_r.gain_i);
      REG_GAIN_D:   prdata = CFG_DW'(cfg_r.gain_d);
      REG_GAIN_DIV: prdata = CFG_DW'(cfg_r.gain_div);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ hdl/ipws_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipws_div
// Serial signed divider: 64-bit dividend by a 10-bit divisor, quotient
// truncated toward zero, several restoring steps per cycle.
// ----------------------------------------------------------------------------
module ipws_div import ipws_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WIDE_W-1:0] dividend,
  input  logic [GAIN_W-1:0]        divisor,
  output logic signed [WIDE_W-1:0] quotient,
  output logic                     done
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

  logic [WIDE_W-1:0]    dvd_r;
  logic [GAIN_W-1:0]    rem_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 fix_r;
  logic                 done_r;

  logic [WIDE_W-1:0]    dvd_nxt;
  logic [GAIN_W-1:0]    rem_nxt;

  // Restoring steps for one cycle: shift a dividend bit in, try subtract
  always_comb begin
    logic [GAIN_W:0] t;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      t       = {rem_nxt, dvd_nxt[WIDE_W-1]};
      dvd_nxt = {dvd_nxt[WIDE_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        rem_nxt    = GAIN_W'(t - {1'b0, divisor});
        dvd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[GAIN_W-1:0];
      end
    end
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        fix_r  <= 1'b1;
      end
    end else if (fix_r) begin
      fix_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Magnitude in, steps, then restore the sign
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend[WIDE_W-1] ? -dividend : dividend;
      rem_r <= '0;
      neg_r <= dividend[WIDE_W-1];
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end else if (fix_r && neg_r) begin
      dvd_r <= -dvd_r;
    end
  end

  assign quotient = signed'(dvd_r);
  assign done     = done_r;

endmodule

@@ hdl/ipws_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipws_dp
// PID datapath: wheel state, saturating 64-bit working registers, the
// shared half-word multiplier, the divider and the result registers.
// ----------------------------------------------------------------------------
module ipws_dp import ipws_pkg::*; #(
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ipws_cmd_t                  cmd,
  output ipws_status_t               status,
  input  ipws_cfg_t                  cfg,
  input  logic                       in_op,
  input  logic signed [ENC_W-1:0]    in_encoder_count,
  input  logic signed [TARGET_W-1:0] in_target_ticks,
  output logic signed [DRIVE_W-1:0]  out_drive,
  output logic                       out_saturated
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned IW = INTEGRAL_WIDTH;
  localparam logic signed [IW-1:0] INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INTEG_MIN = {1'b1, {(IW-1){1'b0}}};

  // Wheel state
  logic [CW-1:0]              last_count_r;
  logic signed [CW-1:0]       last_delta_r;
  logic signed [IW-1:0]       integ_r;
  logic signed [DRIVE_W-1:0]  last_drive_r;

  // Request and working registers
  logic                       op_r;
  logic [CW-1:0]              cnt_r;
  logic signed [TARGET_W-1:0] tgt_r;
  logic signed [WIDE_W-1:0]   delta_r;
  logic signed [WIDE_W-1:0]   err_r;
  logic signed [WIDE_W-1:0]   tmp_r;
  logic signed [WIDE_W-1:0]   ddiff_r;
  logic signed [WIDE_W-1:0]   prod_r;
  logic signed [WIDE_W-1:0]   acc_r;
  logic signed [WIDE_W-1:0]   val_r;
  logic signed [MUL_P_W-1:0]  pp_lo_r;
  logic signed [MUL_P_W-1:0]  pp_hi_r;
  logic signed [DRIVE_W-1:0]  res_drive_r;
  logic                       res_sat_r;
  logic signed [DRIVE_W-1:0]  out_drive_r;
  logic                       out_sat_r;

  logic signed [WIDE_W-1:0]   cnt_ext;
  logic [CW-1:0]              cnt_diff;
  logic signed [WIDE_W-1:0]   tgt_ext;
  logic signed [WIDE_W-1:0]   integ_ext;
  logic signed [WIDE_W-1:0]   err_c;
  logic signed [WIDE_W-1:0]   mul_src;
  logic [GAIN_W-1:0]          mul_gain;
  logic signed [MUL_A_W-1:0]  mul_x;
  logic signed [MUL_G_W-1:0]  mul_y;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [FULL_W-1:0]   full_c;
  logic                       full_fits;
  logic signed [WIDE_W-1:0]   prod_c;
  logic signed [WIDE_W-1:0]   integ_sum;
  logic                       integ_fits;
  logic signed [IW-1:0]       integ_c;
  logic signed [WIDE_W-1:0]   omax_ext;
  logic signed [WIDE_W-1:0]   omin_ext;
  logic                       hi_hit;
  logic                       lo_hit;
  logic signed [DRIVE_W-1:0]  clamp_c;
  logic [GAIN_W-1:0]          div_den;
  logic                       div_start;
  logic signed [WIDE_W-1:0]   div_q;
  logic                       div_done;

  // Extensions of stored values
  assign cnt_ext   = WIDE_W'(in_encoder_count);
  assign cnt_diff  = cnt_r - last_count_r;
  assign tgt_ext   = WIDE_W'(tgt_r);
  assign integ_ext = WIDE_W'(integ_r);
  assign err_c     = sat_add(tgt_ext, tmp_r);

  // Shared multiplier operands
  always_comb begin
    unique case (cmd.msel)
      MS_P: begin
        mul_src  = err_r;
        mul_gain = cfg.gain_p;
      end
      MS_D: begin
        mul_src  = ddiff_r;
        mul_gain = cfg.gain_d;
      end
      MS_I: begin
        mul_src  = err_r;
        mul_gain = cfg.gain_i;
      end
      default: begin
        mul_src  = err_r;
        mul_gain = cfg.gain_p;
      end
    endcase
  end

  always_comb begin
    if (cmd.op == OP_MUL_HI) begin
      mul_x = MUL_A_W'(signed'(mul_src[WIDE_W-1:HALF_W]));
    end else begin
      mul_x = signed'({1'b0, mul_src[HALF_W-1:0]});
    end
  end

  assign mul_y = signed'({1'b0, mul_gain});
  assign mul_p = mul_x * mul_y;

  // Join the half products and saturate to 64 bits
  assign full_c    = (FULL_W'(pp_hi_r) <<< HALF_W) + FULL_W'(pp_lo_r);
  assign full_fits = (&full_c[FULL_W-1:WIDE_W-1]) | ~(|full_c[FULL_W-1:WIDE_W-1]);
  always_comb begin
    if (full_fits) begin
      prod_c = full_c[WIDE_W-1:0];
    end else begin
      prod_c = full_c[FULL_W-1] ? WIDE_MIN : WIDE_MAX;
    end
  end

  // Integral update, saturated to its own width
  assign integ_sum  = sat_add(integ_ext, prod_r);
  assign integ_fits = (&integ_sum[WIDE_W-1:IW-1]) | ~(|integ_sum[WIDE_W-1:IW-1]);
  always_comb begin
    if (integ_fits) begin
      integ_c = integ_sum[IW-1:0];
    end else begin
      integ_c = integ_sum[WIDE_W-1] ? INTEG_MIN : INTEG_MAX;
    end
  end

  // Drive limits, upper one tested first
  assign omax_ext = WIDE_W'(signed'({1'b0, cfg.out_max}));
  assign omin_ext = WIDE_W'(signed'(cfg.out_min));
  assign hi_hit   = (val_r >= omax_ext);
  assign lo_hit   = (val_r <= omin_ext);
  always_comb begin
    if (hi_hit) begin
      clamp_c = signed'({1'b0, cfg.out_max});
    end else if (lo_hit) begin
      clamp_c = signed'(cfg.out_min);
    end else begin
      clamp_c = val_r[DRIVE_W-1:0];
    end
  end

  // Divider, a zero divisor counts as one
  assign div_den   = (cfg.gain_div == '0) ? GAIN_W'(1) : cfg.gain_div;
  assign div_start = (cmd.op == OP_DIV_GO);

  ipws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  // Wheel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      last_delta_r <= '0;
      integ_r      <= '0;
      last_drive_r <= '0;
    end else begin
      case (cmd.op)
        OP_RESET: begin
          last_count_r <= cnt_r;
          last_delta_r <= '0;
          integ_r      <= '0;
          last_drive_r <= '0;
        end
        OP_ERR: begin
          // stopped wheel: drop the integral
          if (tgt_r == '0 && err_c == '0) begin
            integ_r <= '0;
          end
        end
        OP_CLAMP: begin
          last_count_r <= cnt_r;
          last_delta_r <= delta_r[CW-1:0];
          last_drive_r <= clamp_c;
        end
        OP_INTEG: integ_r <= integ_c;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        op_r  <= in_op;
        cnt_r <= cnt_ext[CW-1:0];
        tgt_r <= in_target_ticks;
      end
      OP_RESET: begin
        res_drive_r <= '0;
        res_sat_r   <= 1'b0;
      end
      OP_DELTA:   delta_r <= WIDE_W'(signed'(cnt_diff));
      OP_NEGD:    tmp_r   <= sat_neg(delta_r);
      OP_ERR:     err_r   <= err_c;
      OP_NEGL:    tmp_r   <= sat_neg(WIDE_W'(last_delta_r));
      OP_DDIF:    ddiff_r <= sat_add(delta_r, tmp_r);
      OP_MUL_LO:  pp_lo_r <= mul_p;
      OP_MUL_HI:  pp_hi_r <= mul_p;
      OP_MUL_FIN: prod_r  <= prod_c;
      OP_SETP:    acc_r   <= prod_r;
      OP_NEGP:    tmp_r   <= sat_neg(prod_r);
      OP_SUBD:    acc_r   <= sat_add(acc_r, tmp_r);
      OP_ADDI:    acc_r   <= sat_add(acc_r, integ_ext);
      OP_DRIVE:   val_r   <= sat_add(div_q, WIDE_W'(last_drive_r));
      OP_CLAMP: begin
        res_drive_r <= clamp_c;
        res_sat_r   <= hi_hit | lo_hit;
      end
      OP_OUT: begin
        out_drive_r <= res_drive_r;
        out_sat_r   <= res_sat_r;
      end
      default: ;
    endcase
  end

  assign status.is_reset  = op_r;
  assign status.div_done  = div_done;
  assign status.clamp_hit = hi_hit | lo_hit;

  assign out_drive     = out_drive_r;
  assign out_saturated = out_sat_r;

endmodule

@@ hdl/ipws_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipws_ctrl
// Sequencer for the PID datapath: steps one request through its
// operations and hands the result to the output register.
// ----------------------------------------------------------------------------
module ipws_ctrl import ipws_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output ipws_cmd_t    cmd,
  input  ipws_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DELTA,
    S_RST,
    S_NEGD,
    S_ERR,
    S_NEGL,
    S_DDIF,
    S_P_LO,
    S_P_HI,
    S_P_FIN,
    S_SETP,
    S_D_LO,
    S_D_HI,
    S_D_FIN,
    S_NEGP,
    S_SUBD,
    S_ADDI,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DRIVE,
    S_CLAMP,
    S_I_LO,
    S_I_HI,
    S_I_FIN,
    S_INTEG,
    S_DONE
  } state_e;

  state_e st_r;
  state_e st_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = ~out_valid_r | out_ready;
  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:     if (in_valid) st_nxt = S_DELTA;
      S_DELTA:    st_nxt = status.is_reset ? S_RST : S_NEGD;
      S_RST:      st_nxt = S_DONE;
      S_NEGD:     st_nxt = S_ERR;
      S_ERR:      st_nxt = S_NEGL;
      S_NEGL:     st_nxt = S_DDIF;
      S_DDIF:     st_nxt = S_P_LO;
      S_P_LO:     st_nxt = S_P_HI;
      S_P_HI:     st_nxt = S_P_FIN;
      S_P_FIN:    st_nxt = S_SETP;
      S_SETP:     st_nxt = S_D_LO;
      S_D_LO:     st_nxt = S_D_HI;
      S_D_HI:     st_nxt = S_D_FIN;
      S_D_FIN:    st_nxt = S_NEGP;
      S_NEGP:     st_nxt = S_SUBD;
      S_SUBD:     st_nxt = S_ADDI;
      S_ADDI:     st_nxt = S_DIV_GO;
      S_DIV_GO:   st_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (status.div_done) st_nxt = S_DRIVE;
      S_DRIVE:    st_nxt = S_CLAMP;
      // integral only grows while the drive is inside its limits
      S_CLAMP:    st_nxt = status.clamp_hit ? S_DONE : S_I_LO;
      S_I_LO:     st_nxt = S_I_HI;
      S_I_HI:     st_nxt = S_I_FIN;
      S_I_FIN:    st_nxt = S_INTEG;
      S_INTEG:    st_nxt = S_DONE;
      S_DONE:     if (out_free) st_nxt = S_IDLE;
      default:    st_nxt = S_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd.op   = OP_NOP;
    cmd.msel = MS_P;
    unique case (st_r)
      S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
      S_DELTA:    cmd.op = OP_DELTA;
      S_RST:      cmd.op = OP_RESET;
      S_NEGD:     cmd.op = OP_NEGD;
      S_ERR:      cmd.op = OP_ERR;
      S_NEGL:     cmd.op = OP_NEGL;
      S_DDIF:     cmd.op = OP_DDIF;
      S_P_LO:     cmd.op = OP_MUL_LO;
      S_P_HI:     cmd.op = OP_MUL_HI;
      S_P_FIN:    cmd.op = OP_MUL_FIN;
      S_SETP:     cmd.op = OP_SETP;
      S_D_LO: begin
        cmd.op   = OP_MUL_LO;
        cmd.msel = MS_D;
      end
      S_D_HI: begin
        cmd.op   = OP_MUL_HI;
        cmd.msel = MS_D;
      end
      S_D_FIN: begin
        cmd.op   = OP_MUL_FIN;
        cmd.msel = MS_D;
      end
      S_NEGP:     cmd.op = OP_NEGP;
      S_SUBD:     cmd.op = OP_SUBD;
      S_ADDI:     cmd.op = OP_ADDI;
      S_DIV_GO:   cmd.op = OP_DIV_GO;
      S_DIV_WAIT: cmd.op = OP_NOP;
      S_DRIVE:    cmd.op = OP_DRIVE;
      S_CLAMP:    cmd.op = OP_CLAMP;
      S_I_LO: begin
        cmd.op   = OP_MUL_LO;
        cmd.msel = MS_I;
      end
      S_I_HI: begin
        cmd.op   = OP_MUL_HI;
        cmd.msel = MS_I;
      end
      S_I_FIN: begin
        cmd.op   = OP_MUL_FIN;
        cmd.msel = MS_I;
      end
      S_INTEG:    cmd.op = OP_INTEG;
      S_DONE:     if (out_free) cmd.op = OP_OUT;
      default:    cmd.op = OP_NOP;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/incremental_pid_wheel_speed_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_wheel_speed_unit
// Incremental PID speed controller with anti-windup for one wheel.
// ----------------------------------------------------------------------------
// Each request is either a reset (op = 1), which stores the encoder count and
// returns drive 0, or a control frame (op = 0), which adds the scaled PID
// step to the previous drive, clamps it to [out_min, out_max] and grows the
// integral only while unclamped. One request is handled at a time. Most of
// the time goes to the serial divider, which yields four quotient bits a
// cycle over the 64-bit sum and then fixes the sign, and to the shared
// 33x11 multiplier, through which each 64-bit operand goes in two halves
// before the half products are joined. The result sits in an output
// register, so the next request is taken while it waits.
module incremental_pid_wheel_speed_unit import ipws_pkg::*; #(
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [CFG_DW-1:0]          pwdata,
  output logic [CFG_DW-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic signed [ENC_W-1:0]    in_encoder_count,
  input  logic signed [TARGET_W-1:0] in_target_ticks,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DRIVE_W-1:0]  out_drive,
  output logic                       out_saturated
);

  ipws_cfg_t    cfg;
  ipws_cmd_t    cmd;
  ipws_status_t status;

  // Configuration registers
  ipws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  ipws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath
  ipws_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg              (cfg),
    .in_op            (in_op),
    .in_encoder_count (in_encoder_count),
    .in_target_ticks  (in_target_ticks),
    .out_drive        (out_drive),
    .out_saturated    (out_saturated)
  );

endmodule
